// File: src/udrb_pkg.sv
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and codes for the UART dual ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 6;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // per-item outcome handed from the pointer logic to the result stage
    typedef struct packed {
        logic               tx_pop;
        logic               rx_pop;
        logic               irq_on;
        logic [LEVEL_W-1:0] rx_level;
    } t_ctrl_res;

endpackage

// File: src/udrb_if.sv
// ----------------------------------------------------------------------------
// udrb_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface udrb_in_if;
    import udrb_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] host_byte;
    logic              txe_flag;
    logic              rxne_flag;
    logic [BYTE_W-1:0] line_byte;

    modport source (output valid, kind, host_byte, txe_flag, rxne_flag, line_byte,
                    input ready);
    modport sink   (input valid, kind, host_byte, txe_flag, rxne_flag, line_byte,
                    output ready);
endinterface

interface udrb_out_if;
    import udrb_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  read_byte;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               tx_irq_on;
    logic [LEVEL_W-1:0] rx_level;

    modport source (output valid, read_byte, tx_valid, tx_byte, tx_irq_on, rx_level,
                    input ready);
    modport sink   (input valid, read_byte, tx_valid, tx_byte, tx_irq_on, rx_level,
                    output ready);
endinterface

// File: src/udrb_ram.sv
// ----------------------------------------------------------------------------
// udrb_ram
// Simple dual-port byte RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module udrb_ram
    import udrb_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/udrb_ctrl.sv
// ----------------------------------------------------------------------------
// udrb_ctrl
// Ring pointers and interrupt enable; decides the memory accesses per item.
// ----------------------------------------------------------------------------
module udrb_ctrl
    import udrb_pkg::*;
#(
    parameter int unsigned AW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_kind             i_kind,
    input  logic              i_txe,
    input  logic              i_rxne,
    output logic              o_tx_we,
    output logic [AW-1:0]     o_tx_waddr,
    output logic              o_tx_re,
    output logic [AW-1:0]     o_tx_raddr,
    output logic              o_rx_we,
    output logic [AW-1:0]     o_rx_waddr,
    output logic              o_rx_re,
    output logic [AW-1:0]     o_rx_raddr,
    output t_ctrl_res         o_res
);

    localparam int unsigned LW = (AW > LEVEL_W) ? AW : LEVEL_W;

    logic [AW-1:0] r_tx_head, r_tx_tail, r_rx_head, r_rx_tail;
    logic [AW-1:0] n_tx_head, n_tx_tail, n_rx_head, n_rx_tail;
    logic          r_irq, n_irq;
    logic          tx_full, tx_empty, rx_full, rx_empty;
    logic          tx_pop, rx_pop;
    logic [AW-1:0] level_aw;
    logic [LW-1:0] level_w;

    assign tx_full  = (r_tx_head + AW'(1)) == r_tx_tail;
    assign tx_empty = r_tx_head == r_tx_tail;
    assign rx_full  = (r_rx_head + AW'(1)) == r_rx_tail;
    assign rx_empty = r_rx_head == r_rx_tail;

    always_comb begin
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_irq     = r_irq;
        o_tx_we   = 1'b0;
        o_rx_we   = 1'b0;
        tx_pop    = 1'b0;
        rx_pop    = 1'b0;
        if (i_accept) begin
            unique case (i_kind)
                KIND_WRITE: begin
                    if (!tx_full) begin
                        o_tx_we   = 1'b1;
                        n_tx_head = r_tx_head + AW'(1);
                        n_irq     = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (!rx_empty) begin
                        rx_pop    = 1'b1;
                        n_rx_tail = r_rx_tail + AW'(1);
                    end
                end
                KIND_LINE: begin
                    if (i_txe && !tx_empty) begin
                        // a sent byte ends the event
                        tx_pop    = 1'b1;
                        n_tx_tail = r_tx_tail + AW'(1);
                    end else begin
                        if (i_txe) begin
                            n_irq = 1'b0;
                        end
                        if (i_rxne && !rx_full) begin
                            o_rx_we   = 1'b1;
                            n_rx_head = r_rx_head + AW'(1);
                        end
                    end
                end
                KIND_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_irq     <= 1'b0;
        end else begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_irq     <= n_irq;
        end
    end

    assign o_tx_waddr = r_tx_head;
    assign o_tx_re    = tx_pop;
    assign o_tx_raddr = r_tx_tail;
    assign o_rx_waddr = r_rx_head;
    assign o_rx_re    = rx_pop;
    assign o_rx_raddr = r_rx_tail;

    assign level_aw = n_rx_head - n_rx_tail;
    assign level_w  = LW'(level_aw);

    assign o_res.tx_pop   = tx_pop;
    assign o_res.rx_pop   = rx_pop;
    assign o_res.irq_on   = n_irq;
    assign o_res.rx_level = level_w[LEVEL_W-1:0];

endmodule

// File: src/uart_dual_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_unit
// Transmit and receive byte rings between a host and a serial line.
// ----------------------------------------------------------------------------
// Each item (host write, host read or line event) gives one result item. The
// pointer update and the registered RAM read both happen at the accepting
// edge, and the result register loads as the item leaves stage one. Pointers
// move as an item is taken, so a new item is accepted every cycle while the
// result side takes them. When the result side stalls, the block holds two
// items and then holds off its input. Each ring RAM sees at most one write or
// one read per item, and a write lands before any later read of that slot.
// Each ring holds up to RING_DEPTH-1 bytes. No clearing pass after reset.
module uart_dual_ring_buffer_unit
    import udrb_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    udrb_in_if.sink   i_item,
    udrb_out_if.source o_res
);

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic              accept;
    logic              s1_adv;
    logic              tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0]     tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [BYTE_W-1:0] tx_rdata, rx_rdata;
    t_ctrl_res         ctrl_res;

    logic              r_s1_valid, n_s1_valid;
    t_ctrl_res         r_s1;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_read_byte, r_tx_byte;
    logic              r_tx_valid, r_irq_on;
    logic [LEVEL_W-1:0] r_rx_level;

    assign s1_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_s1_valid || s1_adv;
    assign accept       = i_item.valid && i_item.ready;

    udrb_ctrl #(.AW(AW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (t_kind'(i_item.kind)),
        .i_txe      (i_item.txe_flag),
        .i_rxne     (i_item.rxne_flag),
        .o_tx_we    (tx_we),
        .o_tx_waddr (tx_waddr),
        .o_tx_re    (tx_re),
        .o_tx_raddr (tx_raddr),
        .o_rx_we    (rx_we),
        .o_rx_waddr (rx_waddr),
        .o_rx_re    (rx_re),
        .o_rx_raddr (rx_raddr),
        .o_res      (ctrl_res)
    );

    udrb_ram #(.DEPTH(RING_DEPTH), .AW(AW)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_item.host_byte),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    udrb_ram #(.DEPTH(RING_DEPTH), .AW(AW)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_item.line_byte),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= ctrl_res;
        end
    end

    // RAM read data is valid while the item sits in stage one
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_read_byte <= r_s1.rx_pop ? rx_rdata : '0;
            r_tx_valid  <= r_s1.tx_pop;
            r_tx_byte   <= r_s1.tx_pop ? tx_rdata : '0;
            r_irq_on    <= r_s1.irq_on;
            r_rx_level  <= r_s1.rx_level;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.read_byte = r_read_byte;
    assign o_res.tx_valid  = r_tx_valid;
    assign o_res.tx_byte   = r_tx_byte;
    assign o_res.tx_irq_on = r_irq_on;
    assign o_res.rx_level  = r_rx_level;

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !accept)
        else $error("item taken while stage one is blocked");

    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.tx_valid) |-> (o_res.tx_byte == '0))
        else $error("tx_byte non-zero without tx_valid");

    a_send_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.tx_valid) |-> (o_res.read_byte == '0))
        else $error("line send and host read in one item");

    a_one_ram_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({tx_we, tx_re, rx_we, rx_re}) <= 1)
        else $error("more than one ring access for one item");

endmodule
